// ===== rtl/core/otci_pkg.sv =====
package otci_pkg;

  // default slot limit
  localparam int MAX_SLOTS_DEF = 64;

  // container layout
  localparam logic [31:0] HDR_LEN    = 32'd8;
  localparam logic [31:0] MAGIC_LEN  = 32'd4;
  localparam logic [31:0] MAGIC_WORD = 32'h0043_4150;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_MAGIC       = 3'd1;
  localparam logic [2:0] ST_TRUNC_HDR   = 3'd2;
  localparam logic [2:0] ST_OVER_CAP    = 3'd3;
  localparam logic [2:0] ST_TRUNC_TABLE = 3'd4;

  // slot kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_VALID = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic absorb;
    logic check;
    logic latch_i;
    logic cmp_en;
    logic cmp_self;
    logic form;
    logic last_slot;
    logic clear;
  } cmd_t;

endpackage

// ===== rtl/core/otci_dp.sv =====
module otci_dp #(
  parameter int MAX_SLOTS = otci_pkg::MAX_SLOTS_DEF,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  otci_pkg::cmd_t       cmd,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     slot,
  input  logic [7:0]           data_byte,
  output logic                 single,
  output logic [IDX_W-1:0]     n_m1,
  output logic [CNT_W-1:0]     n_cnt,
  output logic [2:0]           status,
  output logic                 entry_present,
  output logic [5:0]           slot_num,
  output logic [1:0]           entry_kind,
  output logic [31:0]          entry_offset,
  output logic [31:0]          entry_size,
  output logic                 duplicate_seen,
  output logic [31:0]          declared_slots,
  output logic [31:0]          total_size,
  output logic                 last_result
);

  // framing state
  logic [31:0] pos;
  logic [63:0] hdr;
  logic [23:0] word_low;
  logic        dup;

  // offset table
  logic [31:0] mem [MAX_SLOTS];
  logic [31:0] mem_q;

  // check and scan registers
  logic [2:0]  status_q;
  logic        single_q;
  logic [31:0] tab_end;
  logic [31:0] oi;
  logic        vi;
  logic [31:0] end_acc;

  logic [31:0] n;
  logic [31:0] rel;
  logic [31:0] tail;
  logic        in_table;
  logic [2:0]  status_c;
  logic        vj;

  assign n    = hdr[63:32];
  assign rel  = pos - otci_pkg::HDR_LEN;
  assign tail = pos - otci_pkg::HDR_LEN;
  assign in_table = (n <= 32'(MAX_SLOTS)) && ({2'b00, rel[31:2]} < n);

  assign n_m1  = IDX_W'(n - 32'd1);
  assign n_cnt = n[CNT_W-1:0];
  assign single = single_q;

  // slot offset is in range
  function automatic logic in_range(input logic [31:0] o, input logic [31:0] te,
                                    input logic [31:0] tot);
    in_range = (o != 32'd0) && (o >= te) && (o < tot);
  endfunction

  assign vj = in_range(mem_q, tab_end, pos);

  // header checks
  always_comb begin
    if (pos < otci_pkg::MAGIC_LEN || hdr[31:0] != otci_pkg::MAGIC_WORD) begin
      status_c = otci_pkg::ST_MAGIC;
    end else if (pos < otci_pkg::HDR_LEN) begin
      status_c = otci_pkg::ST_TRUNC_HDR;
    end else if (n > 32'(MAX_SLOTS)) begin
      status_c = otci_pkg::ST_OVER_CAP;
    end else if ({n, 2'b00} > {2'b00, tail}) begin
      status_c = otci_pkg::ST_TRUNC_TABLE;
    end else begin
      status_c = otci_pkg::ST_OK;
    end
  end

  // byte capture and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      hdr <= '0;
      dup <= 1'b0;
    end else if (cmd.clear) begin
      pos <= '0;
      hdr <= '0;
      dup <= 1'b0;
    end else begin
      if (cmd.absorb) begin
        if (pos < otci_pkg::HDR_LEN) begin
          hdr[8*pos[2:0] +: 8] <= data_byte;
        end
        if (pos != 32'hFFFF_FFFF) begin
          pos <= pos + 32'd1;
        end
      end
      if (cmd.cmp_en && vi && vj && !cmd.cmp_self && mem_q == oi) begin
        dup <= 1'b1;
      end
    end
  end

  // table word assembly
  always_ff @(posedge clk) begin
    if (cmd.absorb && pos >= otci_pkg::HDR_LEN && in_table) begin
      case (rel[1:0])
        2'd0: word_low[7:0]   <= data_byte;
        2'd1: word_low[15:8]  <= data_byte;
        2'd2: word_low[23:16] <= data_byte;
        default: mem[rel[IDX_W+1:2]] <= {data_byte, word_low};
      endcase
    end
  end

  // table read port
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
  end

  // check result and slot scan
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_q  <= status_c;
      single_q  <= (status_c != otci_pkg::ST_OK) || (n == 32'd0);
      tab_end   <= otci_pkg::HDR_LEN + {n[29:0], 2'b00};
    end
    if (cmd.latch_i) begin
      oi      <= mem_q;
      vi      <= in_range(mem_q, tab_end, pos);
      end_acc <= pos;
    end else if (cmd.cmp_en && vj && mem_q > oi && mem_q < end_acc) begin
      end_acc <= mem_q;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.form) begin
      total_size <= pos;
      if (single_q) begin
        status         <= status_q;
        entry_present  <= 1'b0;
        slot_num       <= '0;
        entry_kind     <= otci_pkg::KIND_EMPTY;
        entry_offset   <= '0;
        entry_size     <= '0;
        duplicate_seen <= 1'b0;
        declared_slots <= (status_q == otci_pkg::ST_MAGIC ||
                           status_q == otci_pkg::ST_TRUNC_HDR) ? 32'd0 : n;
        last_result    <= 1'b1;
      end else begin
        status         <= otci_pkg::ST_OK;
        entry_present  <= 1'b1;
        slot_num       <= 6'(slot);
        duplicate_seen <= dup;
        declared_slots <= n;
        last_result    <= cmd.last_slot;
        if (oi == 32'd0) begin
          entry_kind   <= otci_pkg::KIND_EMPTY;
          entry_offset <= '0;
          entry_size   <= '0;
        end else if (!vi) begin
          entry_kind   <= otci_pkg::KIND_RANGE;
          entry_offset <= '0;
          entry_size   <= '0;
        end else begin
          entry_kind   <= otci_pkg::KIND_VALID;
          entry_offset <= oi;
          entry_size   <= end_acc - oi;
        end
      end
    end
  end

endmodule

// ===== rtl/core/otci_ctrl.sv =====
module otci_ctrl #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last,
  input  logic             empty_resource,
  input  logic             out_stall,
  input  logic             single,
  input  logic [IDX_W-1:0] n_m1,
  input  logic [CNT_W-1:0] n_cnt,
  output logic             in_stall,
  output logic             out_valid,
  output otci_pkg::cmd_t   cmd,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] slot
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_ROUTE  = 3'd2;
  localparam logic [2:0] S_RD_I   = 3'd3;
  localparam logic [2:0] S_LATCH  = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_FORM   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [CNT_W-1:0] j, j_next;
  logic             round, round_next;
  logic             self_q, self_next;
  logic             accept;

  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && (state == S_LOAD);
  assign slot      = i;

  // sequencer
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    round_next = round;
    self_next  = self_q;
    cmd        = '0;
    rd_addr    = i;
    case (state)
      S_LOAD: begin
        cmd.absorb = accept && !empty_resource;
        if (accept && (last || empty_resource)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_ROUTE;
      end
      S_ROUTE: begin
        i_next     = '0;
        round_next = 1'b0;
        state_next = single ? S_FORM : S_RD_I;
      end
      S_RD_I: begin
        rd_addr    = i;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch_i = 1'b1;
        rd_addr     = '0;
        j_next      = CNT_W'(1);
        self_next   = (i == '0);
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        cmd.cmp_en   = 1'b1;
        cmd.cmp_self = self_q;
        if (j == n_cnt) begin
          if (round) begin
            state_next = S_FORM;
          end else begin
            if (i == n_m1) begin
              round_next = 1'b1;
              i_next     = '0;
            end else begin
              i_next = i + IDX_W'(1);
            end
            state_next = S_RD_I;
          end
        end else begin
          rd_addr   = j[IDX_W-1:0];
          j_next    = j + CNT_W'(1);
          self_next = (j[IDX_W-1:0] == i);
        end
      end
      S_FORM: begin
        cmd.form      = 1'b1;
        cmd.last_slot = (i == n_m1);
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (single || i == n_m1) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_RD_I;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      i      <= '0;
      j      <= '0;
      round  <= 1'b0;
      self_q <= 1'b0;
    end else begin
      state  <= state_next;
      i      <= i_next;
      j      <= j_next;
      round  <= round_next;
      self_q <= self_next;
    end
  end

endmodule

// ===== rtl/core/offset_table_container_indexer.sv =====
// Container offset-table indexer. Bytes of a container enter one per cycle while
// in_stall is low; last marks the final byte, and empty_resource ends the container
// without carrying a byte. The block checks the magic word, the slot count against
// MAX_SLOTS and the table length, and stores the little-endian offset table in an
// internal memory. After the end marker it runs the header checks in S_CHECK and S_ROUTE;
// an error or a zero slot count then gives one result word through S_FORM and S_OUT. Otherwise
// every slot entry is compared against every other entry through the single table
// read port, in two passes (the first settles the duplicate flag, the second infers
// sizes and emits): in each pass a slot goes through S_RD_I, S_LATCH and S_SCAN, and
// in the second pass S_FORM and S_OUT then form and present its result, which waits in
// S_OUT while the output is stalled. No new byte is taken
// until the final result word has been accepted.
module offset_table_container_indexer #(
  parameter int MAX_SLOTS = otci_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        empty_resource,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        entry_present,
  output logic [5:0]  slot_num,
  output logic [1:0]  entry_kind,
  output logic [31:0] entry_offset,
  output logic [31:0] entry_size,
  output logic        duplicate_seen,
  output logic [31:0] declared_slots,
  output logic [31:0] total_size,
  output logic        last_result
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  otci_pkg::cmd_t   cmd;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] slot;
  logic             single;
  logic [IDX_W-1:0] n_m1;
  logic [CNT_W-1:0] n_cnt;

  // sequencer
  otci_ctrl #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .last           (last),
    .empty_resource (empty_resource),
    .out_stall      (out_stall),
    .single         (single),
    .n_m1           (n_m1),
    .n_cnt          (n_cnt),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .slot           (slot)
  );

  // capture, table memory and slot scan
  otci_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .slot           (slot),
    .data_byte      (data_byte),
    .single         (single),
    .n_m1           (n_m1),
    .n_cnt          (n_cnt),
    .status         (status),
    .entry_present  (entry_present),
    .slot_num       (slot_num),
    .entry_kind     (entry_kind),
    .entry_offset   (entry_offset),
    .entry_size     (entry_size),
    .duplicate_seen (duplicate_seen),
    .declared_slots (declared_slots),
    .total_size     (total_size),
    .last_result    (last_result)
  );

endmodule

// ===== sim/tb_offset_table_container_indexer.sv =====
module tb_offset_table_container_indexer;

  localparam int SLOT_CAP = otci_pkg::MAX_SLOTS_DEF;

  // one byte word as the sender offers it
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       empty;
    logic       hold;
  } byte_word_t;

  // one slot report as the block should emit it
  typedef struct packed {
    logic [2:0]  status;
    logic        present;
    logic [5:0]  slot;
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [31:0] size;
    logic        dup;
    logic [31:0] declared;
    logic [31:0] total;
    logic        fin;
  } slot_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last = 1'b0;
  logic        empty_resource = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        entry_present;
  logic [5:0]  slot_num;
  logic [1:0]  entry_kind;
  logic [31:0] entry_offset;
  logic [31:0] entry_size;
  logic        duplicate_seen;
  logic [31:0] declared_slots;
  logic [31:0] total_size;
  logic        last_result;

  offset_table_container_indexer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last           (last),
    .empty_resource (empty_resource),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .entry_present  (entry_present),
    .slot_num       (slot_num),
    .entry_kind     (entry_kind),
    .entry_offset   (entry_offset),
    .entry_size     (entry_size),
    .duplicate_seen (duplicate_seen),
    .declared_slots (declared_slots),
    .total_size     (total_size),
    .last_result    (last_result)
  );

  always #10 clk = ~clk;

  // pending words, reports still due, container under construction
  byte_word_t   byte_words[$];
  slot_report_t slot_reports_due[$];
  logic [7:0]   cbytes[$];
  int           queued = 0;
  bit           hold_next = 1'b0;
  int           mismatches = 0;

  // predictor state
  logic [31:0] byte_pos = 32'd0;
  logic [63:0] hdr_bytes = 64'd0;
  logic [31:0] word_acc = 32'd0;
  logic [31:0] pred_offs [SLOT_CAP];

  // driver and monitor pacing
  int          src_wait = 0;
  int          sink_wait = 0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  byte_word_t  cur;

  initial begin
    for (int i = 0; i < SLOT_CAP; i++) pred_offs[i] = 32'd0;
  end

  // end of container: header checks, then one report per slot, or a single report on an error or zero slots
  task automatic index_close();
    logic [31:0]  magic, n, tend, lim, o;
    bit           usable [SLOT_CAP];
    bit           dupf;
    int           i, j;
    slot_report_t r;
    magic = hdr_bytes[31:0];
    n = hdr_bytes[63:32];
    r = '0;
    r.total = byte_pos;
    r.fin = 1'b1;
    if (byte_pos < otci_pkg::MAGIC_LEN || magic != otci_pkg::MAGIC_WORD) begin
      r.status = otci_pkg::ST_MAGIC;
      slot_reports_due.insert(slot_reports_due.size(), r);
    end else if (byte_pos < otci_pkg::HDR_LEN) begin
      r.status = otci_pkg::ST_TRUNC_HDR;
      slot_reports_due.insert(slot_reports_due.size(), r);
    end else if (n > 32'(SLOT_CAP)) begin
      r.status = otci_pkg::ST_OVER_CAP;
      r.declared = n;
      slot_reports_due.insert(slot_reports_due.size(), r);
    end else if ({n[29:0], 2'b00} > byte_pos - otci_pkg::HDR_LEN) begin
      r.status = otci_pkg::ST_TRUNC_TABLE;
      r.declared = n;
      slot_reports_due.insert(slot_reports_due.size(), r);
    end else if (n == 32'd0) begin
      r.status = otci_pkg::ST_OK;
      slot_reports_due.insert(slot_reports_due.size(), r);
    end else begin
      tend = otci_pkg::HDR_LEN + {n[29:0], 2'b00};
      for (i = 0; i < int'(n); i++) begin
        o = pred_offs[i];
        usable[i] = (o != 32'd0) && (o >= tend) && (o < byte_pos);
      end
      dupf = 1'b0;
      for (i = 0; i < int'(n); i++)
        for (j = i + 1; j < int'(n); j++)
          if (usable[i] && usable[j] && pred_offs[i] == pred_offs[j]) dupf = 1'b1;
      for (i = 0; i < int'(n); i++) begin
        r = '0;
        r.status = otci_pkg::ST_OK;
        r.present = 1'b1;
        r.slot = i[5:0];
        r.dup = dupf;
        r.declared = n;
        r.total = byte_pos;
        r.fin = (i + 1 == int'(n));
        o = pred_offs[i];
        if (o == 32'd0) begin
          r.kind = otci_pkg::KIND_EMPTY;
        end else if (!usable[i]) begin
          r.kind = otci_pkg::KIND_RANGE;
        end else begin
          // size runs to the next greater usable offset or the end
          lim = byte_pos;
          for (j = 0; j < int'(n); j++)
            if (usable[j] && pred_offs[j] > o && pred_offs[j] < lim) lim = pred_offs[j];
          r.kind = otci_pkg::KIND_VALID;
          r.offset = o;
          r.size = lim - o;
        end
        slot_reports_due.insert(slot_reports_due.size(), r);
      end
    end
    byte_pos = 32'd0;
    hdr_bytes = 64'd0;
    word_acc = 32'd0;
  endtask

  // one accepted byte word
  task automatic index_byte(input logic [7:0] b, input logic lst, input logic emp);
    logic [31:0] n, rel, idx;
    logic [1:0]  lane;
    if (emp) begin
      index_close();
    end else begin
      if (byte_pos < otci_pkg::HDR_LEN) begin
        hdr_bytes = hdr_bytes | (64'(b) << (8 * byte_pos[2:0]));
      end else begin
        n = hdr_bytes[63:32];
        rel = byte_pos - otci_pkg::HDR_LEN;
        idx = rel >> 2;
        lane = rel[1:0];
        if (n <= 32'(SLOT_CAP) && idx < n) begin
          word_acc = word_acc | (32'(b) << (8 * lane));
          if (lane == 2'd3) begin
            pred_offs[idx[5:0]] = word_acc;
            word_acc = 32'd0;
          end
        end
      end
      if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;
      if (lst) index_close();
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic lst, input logic emp);
    byte_word_t w;
    w.data = b;
    w.fin = lst;
    w.empty = emp;
    w.hold = hold_next;
    hold_next = 1'b0;
    byte_words.insert(byte_words.size(), w);
    queued++;
  endtask

  task automatic put_word32(input logic [31:0] w);
    cbytes.insert(cbytes.size(), w[7:0]);
    cbytes.insert(cbytes.size(), w[15:8]);
    cbytes.insert(cbytes.size(), w[23:16]);
    cbytes.insert(cbytes.size(), w[31:24]);
  endtask

  // ending: 0 last on final byte, 1 empty marker, 2 either
  task automatic emit_container(input int ending);
    int k;
    bit marker;
    marker = (ending == 1) || (ending == 2 && $urandom_range(0, 4) == 0) || (cbytes.size() == 0);
    for (k = 0; k < cbytes.size(); k++)
      push_word(cbytes[k], !marker && (k == cbytes.size() - 1), 1'b0);
    if (marker) push_word(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    cbytes.delete();
  endtask

  // well-formed container with a mix of empty, valid, duplicate and stray offsets
  task automatic add_indexed(input int n, input int extra);
    logic [31:0] tend, tot, o;
    logic [31:0] good[$];
    int          i;
    tend = 32'(8 + 4 * n);
    tot = tend + 32'(extra);
    put_word32(otci_pkg::MAGIC_WORD);
    put_word32(32'(n));
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: o = 32'd0;
        7: begin
          if (good.size() != 0) o = good[$urandom_range(0, good.size() - 1)];
          else o = (extra > 0) ? tend + 32'($urandom_range(0, extra - 1)) : 32'd0;
        end
        8: o = 32'($urandom_range(1, tend - 1));
        9: o = $urandom_range(0, 1) ? tot + 32'($urandom_range(0, 3)) : 32'($urandom);
        default: o = (extra > 0) ? tend + 32'($urandom_range(0, extra - 1)) : 32'd0;
      endcase
      if (o != 32'd0 && o >= tend && o < tot) good.insert(good.size(), o);
      put_word32(o);
    end
    for (i = 0; i < extra; i++) cbytes.insert(cbytes.size(), 8'($urandom));
    emit_container(2);
  endtask

  task automatic add_random_container();
    int          sel, n, m, k;
    logic [31:0] w;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 5) == 0) hold_next = 1'b1;
    if (sel < 70) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      add_indexed(n, $urandom_range(0, 24));
    end else begin
      if (sel < 78) begin
        // count over the limit
        put_word32(otci_pkg::MAGIC_WORD);
        put_word32($urandom_range(0, 1) ? 32'(SLOT_CAP + 1 + $urandom_range(0, 200))
                                        : (32'($urandom) | 32'h100));
        m = $urandom_range(0, 6);
      end else if (sel < 86) begin
        // table cut short
        n = $urandom_range(1, 8);
        put_word32(otci_pkg::MAGIC_WORD);
        put_word32(32'(n));
        m = $urandom_range(0, 4 * n - 1);
      end else if (sel < 92) begin
        // one magic bit flipped
        w = otci_pkg::MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31));
        put_word32(w);
        m = $urandom_range(0, 8);
      end else if (sel < 96) begin
        // header cut short
        put_word32(otci_pkg::MAGIC_WORD);
        m = $urandom_range(0, 3);
      end else begin
        m = $urandom_range(1, 10);
      end
      for (k = 0; k < m; k++) cbytes.insert(cbytes.size(), 8'($urandom));
      emit_container(2);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_report();
    slot_report_t r;
    if (slot_reports_due.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual slot %0d status %0d",
               $time, slot_num, status);
      mismatches++;
    end else begin
      r = slot_reports_due.pop_front();
      cmp_field("status", 32'(r.status), 32'(status));
      cmp_field("entry_present", 32'(r.present), 32'(entry_present));
      cmp_field("slot_num", 32'(r.slot), 32'(slot_num));
      cmp_field("entry_kind", 32'(r.kind), 32'(entry_kind));
      cmp_field("entry_offset", r.offset, entry_offset);
      cmp_field("entry_size", r.size, entry_size);
      cmp_field("duplicate_seen", 32'(r.dup), 32'(duplicate_seen));
      cmp_field("declared_slots", r.declared, declared_slots);
      cmp_field("total_size", r.total, total_size);
      cmp_field("last_result", 32'(r.fin), 32'(last_result));
    end
  endtask

  // byte word driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_wait = 0;
    end else begin
      if (in_valid && !in_stall) index_byte(data_byte, last, empty_resource);
      if (!in_valid || !in_stall) begin
        if (src_wait > 0) begin
          src_wait = src_wait - 1;
          in_valid <= 1'b0;
        end else if (byte_words.size() != 0 &&
                     !(byte_words[0].hold && slot_reports_due.size() != 0)) begin
          cur = byte_words.pop_front();
          data_byte <= cur.data;
          last <= cur.fin;
          empty_resource <= cur.empty;
          in_valid <= 1'b1;
          if ($urandom_range(0, 15) == 0) src_quiet = !src_quiet;
          src_wait = src_quiet ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_report();
        if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
        sink_wait = sink_quiet ? 0 : $urandom_range(0, 3);
      end else if (sink_wait > 0) begin
        sink_wait = sink_wait - 1;
      end
      out_stall <= (sink_wait != 0);
    end
  end

  // stimulus and end of run
  initial begin
    // lone empty marker
    emit_container(1);
    // two magic bytes only
    cbytes.insert(cbytes.size(), 8'(otci_pkg::MAGIC_WORD));
    cbytes.insert(cbytes.size(), 8'(otci_pkg::MAGIC_WORD >> 8));
    emit_container(0);
    // magic, one count byte, then the empty marker
    put_word32(otci_pkg::MAGIC_WORD);
    cbytes.insert(cbytes.size(), 8'hFF);
    emit_container(1);
    // zero slots
    put_word32(otci_pkg::MAGIC_WORD);
    put_word32(32'd0);
    emit_container(0);
    // one slot over the limit
    put_word32(otci_pkg::MAGIC_WORD);
    put_word32(32'(SLOT_CAP + 1));
    emit_container(0);
    // full table, sender waits for the previous reports first
    hold_next = 1'b1;
    add_indexed(SLOT_CAP, 16);
    while (queued < 430) add_random_container();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (byte_words.size() != 0 || in_valid) @(posedge clk);
    while (slot_reports_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && slot_reports_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
